>>> design/lsd_pkg.sv
// Shared constants and helpers for the decimal radix sorter.
package lsd_pkg;

    // Default configuration
    localparam int DefMaxItems  = 64;
    localparam int DefValueBits = 31;

    // Stream field widths
    localparam int FieldBits = 31;
    localparam int TdataBits = 32;

    // Decimal radix and digit width
    localparam int Radix     = 10;
    localparam int DigitBits = 4;

    // Number of decimal digits needed for any value of the given bit width
    function automatic int bcd_digits(input int bits);
        return (bits * 30103) / 100000 + 1;
    endfunction

endpackage

>>> design/lsd_decimal_radix_sorter_core.sv
// Top level of the decimal LSD radix sorter: load, sort passes and emit.
// Load: one item at a time, each through the bit-serial BCD conversion unit.
// Sort: one pass per decimal digit of the largest value over the loaded items
// (counting sweep, nine prefix-sum steps, reverse scatter sweep over one RAM port).
// Emit: sorted values go out in order as the sink is ready; next set loads after.
// Reset: asynchronous, clears sequencer, counts and flags; buffers stay undefined.
module lsd_decimal_radix_sorter_core #(
    parameter int MAX_ITEMS  = lsd_pkg::DefMaxItems,
    parameter int VALUE_BITS = lsd_pkg::DefValueBits
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lsd_pkg::TdataBits-1:0] s_tdata,   // [30:0] value, [31] zero
    input  logic                          s_tlast,   // is_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsd_pkg::TdataBits-1:0] m_tdata,   // [30:0] sorted_value, [31] zero
    output logic                          m_tlast    // last_out
);

    localparam int NDIG   = lsd_pkg::bcd_digits(VALUE_BITS);
    localparam int ND_W   = $clog2(NDIG + 1);
    localparam int DSEL_W = $clog2(NDIG);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int ADDR_W = $clog2(2 * MAX_ITEMS);
    localparam int ENT_W  = VALUE_BITS + NDIG * lsd_pkg::DigitBits;
    localparam int DW     = lsd_pkg::DigitBits;

    typedef enum logic [7:0] {
        S_LOAD     = 8'b0000_0001,
        S_CONV     = 8'b0000_0010,
        S_CNT      = 8'b0000_0100,
        S_PFX      = 8'b0000_1000,
        S_SCAT     = 8'b0001_0000,
        S_OUT_RD   = 8'b0010_0000,
        S_OUT_LD   = 8'b0100_0000,
        S_OUT_SEND = 8'b1000_0000
    } state_t;

    state_t                         state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [ND_W-1:0]                ndig_reg, ndig_next;
    logic [DSEL_W-1:0]              pass_reg, pass_next;
    logic [CNT_W-1:0]               idx_reg, idx_next;
    logic [DW-1:0]                  pfx_reg, pfx_next;
    logic                           bank_reg, bank_next;
    logic                           rvld_reg, rvld_next;
    logic                           last_reg, last_next;
    logic [VALUE_BITS-1:0]          value_reg, value_next;
    logic [CNT_W-1:0]               counts_reg [lsd_pkg::Radix];
    logic [CNT_W-1:0]               counts_next [lsd_pkg::Radix];
    logic [lsd_pkg::FieldBits-1:0]  out_data_reg, out_data_next;
    logic                           out_last_reg, out_last_next;

    logic [ENT_W-1:0]               mem [2 * MAX_ITEMS];
    logic [ENT_W-1:0]               rdata_reg;
    logic [ENT_W-1:0]               wdata;
    logic [ADDR_W-1:0]              waddr, raddr;
    logic                           we;

    logic                           conv_start;
    logic                           conv_done;
    logic [NDIG-1:0][DW-1:0]        conv_bcd;
    logic [ND_W-1:0]                conv_ndig;
    logic [VALUE_BITS-1:0]          in_value;
    logic [DW-1:0]                  rd_digit;

    // Map a bank and an index onto the shared buffer RAM
    function automatic logic [ADDR_W-1:0] buf_addr(input logic bank,
                                                   input logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = bank ? ADDR_W'(MAX_ITEMS) : '0;
        return base + ADDR_W'(idx);
    endfunction

    assign in_value = VALUE_BITS'(s_tdata[lsd_pkg::FieldBits-1:0]);
    assign rd_digit = rdata_reg[VALUE_BITS + DW * int'(pass_reg) +: DW];

    lsd_bcd_conv #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG),
        .ND_W       (ND_W)
    ) u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .bin   (in_value),
        .done  (conv_done),
        .bcd   (conv_bcd),
        .ndig  (conv_ndig)
    );

    // Sequencer
    always_comb
    begin
        logic [ND_W-1:0]  nd_new;
        logic [CNT_W-1:0] pos;

        state_next    = state_reg;
        count_next    = count_reg;
        ndig_next     = ndig_reg;
        pass_next     = pass_reg;
        idx_next      = idx_reg;
        pfx_next      = pfx_reg;
        bank_next     = bank_reg;
        rvld_next     = 1'b0;
        last_next     = last_reg;
        value_next    = value_reg;
        counts_next   = counts_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        we            = 1'b0;
        waddr         = '0;
        wdata         = '0;
        raddr         = '0;
        conv_start    = 1'b0;
        nd_new        = ndig_reg;
        pos           = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (s_tvalid)
                begin
                    last_next = s_tlast;
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        value_next = in_value;
                        conv_start = 1'b1;
                        state_next = S_CONV;
                    end
                    else if (s_tlast)
                    begin
                        // Set full: drop the beat but start the sort
                        pass_next  = '0;
                        idx_next   = '0;
                        for (int i = 0; i < lsd_pkg::Radix; i++)
                        begin
                            counts_next[i] = '0;
                        end
                        state_next = (ndig_reg == '0) ? S_OUT_RD : S_CNT;
                    end
                end
            end
            S_CONV:
            begin
                if (conv_done)
                begin
                    we         = 1'b1;
                    waddr      = buf_addr(bank_reg, count_reg[IDX_W-1:0]);
                    wdata      = {conv_bcd, value_reg};
                    count_next = count_reg + CNT_W'(1);
                    nd_new     = (conv_ndig > ndig_reg) ? conv_ndig : ndig_reg;
                    ndig_next  = nd_new;
                    if (last_reg)
                    begin
                        pass_next  = '0;
                        idx_next   = '0;
                        for (int i = 0; i < lsd_pkg::Radix; i++)
                        begin
                            counts_next[i] = '0;
                        end
                        state_next = (nd_new == '0) ? S_OUT_RD : S_CNT;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_CNT:
            begin
                // Sweep forward, tally the digit of each entry
                if (idx_reg != count_reg)
                begin
                    raddr     = buf_addr(bank_reg, idx_reg[IDX_W-1:0]);
                    idx_next  = idx_reg + CNT_W'(1);
                    rvld_next = 1'b1;
                end
                if (rvld_reg)
                begin
                    counts_next[rd_digit] = counts_reg[rd_digit] + CNT_W'(1);
                end
                if (idx_reg == count_reg && !rvld_reg)
                begin
                    pfx_next   = DW'(1);
                    state_next = S_PFX;
                end
            end
            S_PFX:
            begin
                // Accumulate one digit bin per cycle
                counts_next[pfx_reg] = counts_reg[pfx_reg] + counts_reg[pfx_reg - DW'(1)];
                if (pfx_reg == DW'(lsd_pkg::Radix - 1))
                begin
                    idx_next   = count_reg;
                    state_next = S_SCAT;
                end
                else
                begin
                    pfx_next = pfx_reg + DW'(1);
                end
            end
            S_SCAT:
            begin
                // Sweep backward, place each entry into the other bank
                if (idx_reg != '0)
                begin
                    raddr     = buf_addr(bank_reg, IDX_W'(idx_reg - CNT_W'(1)));
                    idx_next  = idx_reg - CNT_W'(1);
                    rvld_next = 1'b1;
                end
                if (rvld_reg)
                begin
                    pos                   = counts_reg[rd_digit] - CNT_W'(1);
                    we                    = 1'b1;
                    waddr                 = buf_addr(!bank_reg, pos[IDX_W-1:0]);
                    wdata                 = rdata_reg;
                    counts_next[rd_digit] = pos;
                end
                if (idx_reg == '0 && !rvld_reg)
                begin
                    bank_next = !bank_reg;
                    idx_next  = '0;
                    if ((ND_W'(pass_reg) + ND_W'(1)) == ndig_reg)
                    begin
                        pass_next  = '0;
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        pass_next = pass_reg + DSEL_W'(1);
                        for (int i = 0; i < lsd_pkg::Radix; i++)
                        begin
                            counts_next[i] = '0;
                        end
                        state_next = S_CNT;
                    end
                end
            end
            S_OUT_RD:
            begin
                raddr      = buf_addr(bank_reg, idx_reg[IDX_W-1:0]);
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                out_data_next = lsd_pkg::FieldBits'(rdata_reg[VALUE_BITS-1:0]);
                out_last_next = (idx_reg + CNT_W'(1)) == count_reg;
                state_next    = S_OUT_SEND;
            end
            S_OUT_SEND:
            begin
                if (m_tready)
                begin
                    if (out_last_reg)
                    begin
                        // Run done: return to an empty set
                        count_next = '0;
                        ndig_next  = '0;
                        idx_next   = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ndig_reg  <= '0;
            pass_reg  <= '0;
            idx_reg   <= '0;
            pfx_reg   <= '0;
            bank_reg  <= 1'b0;
            rvld_reg  <= 1'b0;
            last_reg  <= 1'b0;
            for (int i = 0; i < lsd_pkg::Radix; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ndig_reg   <= ndig_next;
            pass_reg   <= pass_next;
            idx_reg    <= idx_next;
            pfx_reg    <= pfx_next;
            bank_reg   <= bank_next;
            rvld_reg   <= rvld_next;
            last_reg   <= last_next;
            counts_reg <= counts_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Two-bank buffer RAM, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = (state_reg == S_OUT_SEND);
    assign m_tdata  = {1'b0, out_data_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> design/lsd_bcd_conv.sv
// Iterative binary to BCD converter, one bit per cycle, with digit count.
module lsd_bcd_conv #(
    parameter int VALUE_BITS = lsd_pkg::DefValueBits,
    parameter int NDIG       = lsd_pkg::bcd_digits(lsd_pkg::DefValueBits),
    parameter int ND_W       = $clog2(NDIG + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [VALUE_BITS-1:0]                bin,
    output logic                                 done,
    output logic [NDIG-1:0][lsd_pkg::DigitBits-1:0] bcd,
    output logic [ND_W-1:0]                      ndig
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int SH_W  = NDIG * lsd_pkg::DigitBits + VALUE_BITS;

    logic                                     busy_reg, busy_next;
    logic                                     done_reg, done_next;
    logic [CNT_W-1:0]                         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0]                    bin_reg, bin_next;
    logic [NDIG-1:0][lsd_pkg::DigitBits-1:0]  bcd_reg, bcd_next;
    logic [NDIG-1:0][lsd_pkg::DigitBits-1:0]  adj;
    logic [SH_W-1:0]                          sh;

    // Add three to every digit of five or more, then shift in the next bit
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
        sh = {adj, bin_reg} << 1;
    end

    // Sequence the shift steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_BITS);
            bin_next  = bin;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = sh[SH_W-1:VALUE_BITS];
            bin_next = sh[VALUE_BITS-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold the working value and digits
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // Count the digits up to the highest nonzero one
    always_comb
    begin
        ndig = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i] != '0)
            begin
                ndig = ND_W'(i + 1);
            end
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule
